@@ sv/bounded_deque_defines.svh @@
// Assertion macros used by the bounded deque control (bdq_ctrl).
// Depends on: nothing; expects clk and rst_n in the using module.
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// Property checked every cycle outside reset.
`define BDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bdq_pkg.sv @@
// Package for the bounded deque: codes, state type, memory command struct, widths and defaults.
// Depends on: nothing.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int DEFAULT_CAPACITY = 256;
  localparam int VALUE_W          = 32;
  localparam int COUNT_OUT_W      = 9;

  typedef enum logic [1:0] {
    KIND_INS_FRONT = 2'd0,
    KIND_INS_BACK  = 2'd1,
    KIND_REM_FRONT = 2'd2,
    KIND_REM_BACK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_FULL        = 2'd1,
    STAT_EMPTY       = 2'd2,
    STAT_NOT_CREATED = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

`default_nettype wire

@@ sv/bounded_deque.sv @@
// Bounded double-ended queue of signed 32-bit items, top level.
// Depends on: bdq_pkg, bdq_ctrl, bdq_ram.
//
// Usage:
//   Input channel (in_valid / in_stall): in_kind selects insert front, insert back,
//   remove front or remove back; in_item_value is the item for inserts.
//   Result channel (out_valid / out_stall): one result per request with out_status,
//   out_removed_value (zero unless a removal succeeds) and out_entry_count.
//   Inserts and error results go straight into the output register; successful
//   removals pass through the ring memory's read register, then the read state loads
//   them into the output register once it is free. Throughput: one insert or error per
//   cycle while out_stall allows; a successful removal stalls input in the read state.
//   Reset: indices, count and created flag clear; the queue reports never created
//   on removals until the first insert. Memory contents are not cleared.
//   Stall: the result stays in its output register while out_stall is high; one
//   new request is still taken if the register is being freed that cycle.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque #(
  parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY,
  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_kind,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0]  in_item_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_status,
  output logic signed [bdq_pkg::VALUE_W-1:0]       out_removed_value,
  output logic [bdq_pkg::COUNT_OUT_W-1:0]          out_entry_count
);

  bdq_pkg::mem_cmd_t            mem_cmd;
  logic [ADDR_W-1:0]            mem_addr;
  logic [bdq_pkg::VALUE_W-1:0]  mem_wdata;
  logic [bdq_pkg::VALUE_W-1:0]  mem_rdata;

  bdq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count),
    .mem_cmd           (mem_cmd),
    .mem_addr          (mem_addr),
    .mem_wdata         (mem_wdata),
    .mem_rdata         (mem_rdata)
  );

  bdq_ram #(
    .CAPACITY (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

@@ sv/bdq_ram.sv @@
// Ring store for the bounded deque: one shared address, registered read data.
// Depends on: bdq_pkg (command struct, widths).
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
  parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY,
  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                          clk,
  input  wire bdq_pkg::mem_cmd_t             cmd,
  input  wire logic [ADDR_W-1:0]             addr,
  input  wire logic [bdq_pkg::VALUE_W-1:0]   wdata,
  output logic      [bdq_pkg::VALUE_W-1:0]   rdata
);

  logic [bdq_pkg::VALUE_W-1:0] store_mem [CAPACITY];
  logic [bdq_pkg::VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store_mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= store_mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ sv/bdq_ctrl.sv @@
// Deque control: ring indices, count, created flag, sequencer and result register.
// Depends on: bdq_pkg, bounded_deque_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_defines.svh"

module bdq_ctrl #(
  parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY,
  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int COUNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_kind,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0]  in_item_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_status,
  output logic signed [bdq_pkg::VALUE_W-1:0]       out_removed_value,
  output logic [bdq_pkg::COUNT_OUT_W-1:0]          out_entry_count,
  output bdq_pkg::mem_cmd_t                        mem_cmd,
  output logic [ADDR_W-1:0]                        mem_addr,
  output logic [bdq_pkg::VALUE_W-1:0]              mem_wdata,
  input  wire logic [bdq_pkg::VALUE_W-1:0]         mem_rdata
);

  localparam logic [ADDR_W-1:0]  LAST_IDX = ADDR_W'(CAPACITY - 1);
  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(CAPACITY);

  bdq_pkg::state_t  state_r, state_nxt;
  logic [ADDR_W-1:0]  front_r, front_nxt;
  logic [ADDR_W-1:0]  back_r, back_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               created_r, created_nxt;
  logic               out_valid_r, out_valid_nxt;
  bdq_pkg::status_t   out_status_r, out_status_nxt;
  logic [bdq_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic              out_free;
  logic              in_accept;
  logic [ADDR_W-1:0] front_dec, front_inc, back_dec, back_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != bdq_pkg::ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - ADDR_W'(1);
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + ADDR_W'(1);
  assign back_dec  = (back_r == '0) ? LAST_IDX : back_r - ADDR_W'(1);
  assign back_inc  = (back_r == LAST_IDX) ? '0 : back_r + ADDR_W'(1);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    count_nxt      = count_r;
    created_nxt    = created_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    mem_cmd        = '0;
    mem_addr       = front_r;
    mem_wdata      = $unsigned(in_item_value);

    unique case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (in_accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bdq_pkg::STAT_OK;
          out_value_nxt  = '0;
          out_count_nxt  = count_r;
          unique case (bdq_pkg::kind_t'(in_kind))
            bdq_pkg::KIND_INS_FRONT, bdq_pkg::KIND_INS_BACK: begin
              created_nxt = 1'b1;
              if (count_r == FULL_CNT) begin
                out_status_nxt = bdq_pkg::STAT_FULL;
              end else begin
                mem_cmd.wr_en = 1'b1;
                count_nxt     = count_r + COUNT_W'(1);
                out_count_nxt = count_r + COUNT_W'(1);
                if (bdq_pkg::kind_t'(in_kind) == bdq_pkg::KIND_INS_FRONT) begin
                  front_nxt = front_dec;
                  mem_addr  = front_dec;
                end else begin
                  back_nxt = back_inc;
                  mem_addr = back_r;
                end
              end
            end
            bdq_pkg::KIND_REM_FRONT, bdq_pkg::KIND_REM_BACK: begin
              if (!created_r) begin
                out_status_nxt = bdq_pkg::STAT_NOT_CREATED;
              end else if (count_r == '0) begin
                out_status_nxt = bdq_pkg::STAT_EMPTY;
              end else begin
                mem_cmd.rd_en = 1'b1;
                count_nxt     = count_r - COUNT_W'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = bdq_pkg::ST_READ;
                if (bdq_pkg::kind_t'(in_kind) == bdq_pkg::KIND_REM_FRONT) begin
                  front_nxt = front_inc;
                  mem_addr  = front_r;
                end else begin
                  back_nxt = back_dec;
                  mem_addr = back_dec;
                end
              end
            end
          endcase
        end
      end
      bdq_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bdq_pkg::STAT_OK;
          out_value_nxt  = mem_rdata;
          out_count_nxt  = count_r;
          state_nxt      = bdq_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::ST_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      created_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      created_r   <= created_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = $signed(out_value_r);
  assign out_entry_count   = bdq_pkg::COUNT_OUT_W'(out_count_r);

  `BDQ_ASSERT(a_count_bound, count_r <= FULL_CNT, "count above capacity")
  `BDQ_ASSERT(a_ring_agree, (count_r != '0 && count_r != FULL_CNT) || front_r == back_r, "indices disagree with count")
  `BDQ_ASSERT(a_read_created, state_r != bdq_pkg::ST_READ || (created_r && !mem_cmd.wr_en), "bad access during read")
  `BDQ_ASSERT_NEXT(a_read_follows, mem_cmd.rd_en, state_r == bdq_pkg::ST_READ && !out_valid_r, "read not followed by result")

endmodule

`default_nettype wire
